/* rtl/ipf_pkg.sv */
// ----------------------------------------------------------------------------
// ipf_pkg
// Shared types and constants for the integer predicate filter.
// ----------------------------------------------------------------------------
package ipf_pkg;

  localparam int VALUE_BITS = 16;
  localparam int MAG_BITS   = VALUE_BITS;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);
  // trial divisor never passes 182 (182^2 > 32767)
  localparam int DIV_BITS   = 8;
  localparam int REM_BITS   = DIV_BITS;
  localparam int SQ_BITS    = 16;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;
  localparam int MODE_BITS  = 2;

  localparam logic [MODE_BITS-1:0] MODE_MUL7  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_MUL77 = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_PRIME = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_EVEN  = 2'd3;

  localparam logic REG_IDX_FILTER_MODE = 1'b0;

  localparam logic [DIV_BITS-1:0] DIVISOR_7     = 8'd7;
  localparam logic [DIV_BITS-1:0] FIRST_TRIAL   = 8'd2;
  localparam logic [SQ_BITS-1:0]  FIRST_SQUARE  = 16'd4;
  // 4 * 11, keeps the alternating 5-bit chunk sum positive
  localparam logic [6:0]          MOD11_BIAS    = 7'd44;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CHECK,
    ST_DIV,
    ST_REM,
    ST_EMIT
  } state_t;

endpackage

/* rtl/integer_predicate_filter.sv */
// ----------------------------------------------------------------------------
// integer_predicate_filter
// Passes a signed word on when it meets the predicate picked by filter_mode; in prime
// mode negative words go out flagged; a small sequencer runs one remainder unit.
// ----------------------------------------------------------------------------
// Even, multiple-of-7 and multiple-of-77 modes, and a negative word in prime mode,
// are decided in SETUP; prime mode runs CHECK, DIV and REM per trial divisor.
// One word at a time: busy stays high until the result (if any) is out; the next
// word is taken only once back in idle. Remainder unit: one bit per cycle.
// Result strobe lasts one cycle; the receiver cannot stall it.
// Synchronous active-high reset returns to idle with filter_mode = 0.
module integer_predicate_filter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [ipf_pkg::VALUE_BITS-1:0] value,
  output logic                                 result_valid,
  output logic signed [ipf_pkg::VALUE_BITS-1:0] passed_value,
  output logic                                 negative_error,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ipf_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [ipf_pkg::DATA_BITS-1:0]        pwdata,
  output logic [ipf_pkg::DATA_BITS-1:0]        prdata,
  output logic                                 pready
);

  ipf_pkg::state_t state, state_next;

  logic [ipf_pkg::MODE_BITS-1:0]        filter_mode;
  logic signed [ipf_pkg::VALUE_BITS-1:0] val;
  logic [ipf_pkg::MAG_BITS-1:0]         mag;
  logic [ipf_pkg::MAG_BITS-1:0]         dvd;
  logic [ipf_pkg::REM_BITS-1:0]         rem;
  logic [ipf_pkg::DIV_BITS-1:0]         divisor;
  logic [ipf_pkg::SQ_BITS-1:0]          sq;
  logic [ipf_pkg::CNT_BITS-1:0]         cnt;
  logic                                 err;

  logic [ipf_pkg::REM_BITS:0]           rem_sh;
  logic [ipf_pkg::REM_BITS:0]           rem_sub;
  logic                                 rem_ge;
  logic [ipf_pkg::REM_BITS-1:0]         rem_next;
  logic                                 cfg_wr;
  logic                                 accept;
  logic                                 last_bit;
  logic                                 rem_zero;

  logic [5:0]                           m7_sum1;
  logic [3:0]                           m7_sum2;
  logic [3:0]                           m7_fold;
  logic                                 mul7;
  logic [6:0]                           m11_fold;
  logic                                 mul11;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[ipf_pkg::ADDR_BITS-1] == ipf_pkg::REG_IDX_FILTER_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= ipf_pkg::MODE_MUL7;
    end else if (cfg_wr) begin
      filter_mode <= pwdata[ipf_pkg::MODE_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ipf_pkg::ADDR_BITS-1] == ipf_pkg::REG_IDX_FILTER_MODE) begin
      prdata[ipf_pkg::MODE_BITS-1:0] = filter_mode;
    end
  end

  // ---------------- constant divisibility ----------------
  // 8 = 1 (mod 7): summing 3-bit chunks keeps the residue; ends in 0..7
  assign m7_sum1 = 6'(mag[2:0]) + 6'(mag[5:3]) + 6'(mag[8:6]) + 6'(mag[11:9]) +
                   6'(mag[14:12]) + 6'(mag[15]);
  assign m7_sum2 = 4'(m7_sum1[2:0]) + 4'(m7_sum1[5:3]);
  assign m7_fold = 4'(m7_sum2[2:0]) + 4'(m7_sum2[3]);
  assign mul7    = (m7_fold == '0) || (m7_fold == 4'(ipf_pkg::DIVISOR_7));

  // 32 = -1 (mod 11): alternating sum of 5-bit chunks, lands in 12..106
  assign m11_fold = 7'(mag[4:0]) + 7'(mag[14:10]) + ipf_pkg::MOD11_BIAS -
                    7'(mag[9:5]) - 7'(mag[15]);
  assign mul11    = (m11_fold inside {7'd22, 7'd33, 7'd44, 7'd55, 7'd66, 7'd77, 7'd88,
                                      7'd99});

  // ---------------- shared remainder unit ----------------
  assign rem_sh   = {rem, dvd[ipf_pkg::MAG_BITS-1]};
  assign rem_sub  = rem_sh - {1'b0, divisor};
  assign rem_ge   = (rem_sh >= {1'b0, divisor});
  // remainder stays below the divisor, so it fits back in REM_BITS
  assign rem_next = rem_ge ? rem_sub[ipf_pkg::REM_BITS-1:0] : rem_sh[ipf_pkg::REM_BITS-1:0];
  assign last_bit = (cnt == ipf_pkg::CNT_BITS'(ipf_pkg::VALUE_BITS - 1));
  assign rem_zero = (rem == '0);

  assign accept = start && (state == ipf_pkg::ST_IDLE);

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      ipf_pkg::ST_IDLE: begin
        if (start) state_next = ipf_pkg::ST_SETUP;
      end
      ipf_pkg::ST_SETUP: begin
        case (filter_mode)
          ipf_pkg::MODE_EVEN: begin
            state_next = mag[0] ? ipf_pkg::ST_IDLE : ipf_pkg::ST_EMIT;
          end
          ipf_pkg::MODE_PRIME: begin
            if (val < 0) state_next = ipf_pkg::ST_EMIT;
            else if (mag < ipf_pkg::MAG_BITS'(2)) state_next = ipf_pkg::ST_IDLE;
            else state_next = ipf_pkg::ST_CHECK;
          end
          ipf_pkg::MODE_MUL7: begin
            state_next = mul7 ? ipf_pkg::ST_EMIT : ipf_pkg::ST_IDLE;
          end
          default: begin
            state_next = (mul7 && mul11) ? ipf_pkg::ST_EMIT : ipf_pkg::ST_IDLE;
          end
        endcase
      end
      ipf_pkg::ST_CHECK: begin
        state_next = (sq > mag) ? ipf_pkg::ST_EMIT : ipf_pkg::ST_DIV;
      end
      ipf_pkg::ST_DIV: begin
        if (last_bit) state_next = ipf_pkg::ST_REM;
      end
      ipf_pkg::ST_REM: begin
        // a zero remainder means a factor was found
        state_next = rem_zero ? ipf_pkg::ST_IDLE : ipf_pkg::ST_CHECK;
      end
      ipf_pkg::ST_EMIT: state_next = ipf_pkg::ST_IDLE;
      default: state_next = ipf_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    busy         = 1'b1;
    result_valid = 1'b0;
    case (state)
      ipf_pkg::ST_IDLE: busy = 1'b0;
      ipf_pkg::ST_EMIT: result_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      val <= value;
      mag <= value[ipf_pkg::VALUE_BITS-1] ? ipf_pkg::MAG_BITS'(-value)
                                          : ipf_pkg::MAG_BITS'(value);
      err <= 1'b0;
    end
    case (state)
      ipf_pkg::ST_SETUP: begin
        rem     <= '0;
        dvd     <= mag;
        cnt     <= '0;
        sq      <= ipf_pkg::FIRST_SQUARE;
        divisor <= ipf_pkg::FIRST_TRIAL;
        err     <= (filter_mode == ipf_pkg::MODE_PRIME) && (val < 0);
      end
      ipf_pkg::ST_CHECK: begin
        rem <= '0;
        dvd <= mag;
        cnt <= '0;
      end
      ipf_pkg::ST_DIV: begin
        rem <= rem_next;
        dvd <= {dvd[ipf_pkg::MAG_BITS-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      ipf_pkg::ST_REM: begin
        rem     <= '0;
        dvd     <= mag;
        cnt     <= '0;
        // (d+1)^2 = d^2 + 2d + 1
        sq      <= sq + ipf_pkg::SQ_BITS'({divisor, 1'b1});
        divisor <= divisor + 1'b1;
      end
      default: ;
    endcase
  end

  assign passed_value   = val;
  assign negative_error = err;

endmodule
